// File: design/point_slab_pixel_projector_defines.svh
// assertion macros used by the point slab pixel projector
`ifndef POINT_SLAB_PIXEL_PROJECTOR_DEFINES_SVH
`define POINT_SLAB_PIXEL_PROJECTOR_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PSP_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("psp assertion failed");

// consequence a fixed number of cycles later
`define PSP_ASSERT_DELAY(label, clk_s, rstn_s, ante, n, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> ##n (cons)) \
        else $error("psp latency assertion failed");

`else

`define PSP_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons)
`define PSP_ASSERT_DELAY(label, clk_s, rstn_s, ante, n, cons)

`endif

`endif

// File: design/psp_pkg.sv
// types, widths and register codes of the point slab pixel projector
`default_nettype none

package psp_pkg;

    localparam int MASK_DIM_BITS = 12;
    localparam int DIM_W         = MASK_DIM_BITS;
    localparam int PIX_W         = 12;
    localparam int COORD_W       = 16;
    localparam int COEF_W        = 16;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int NORMAL_W      = 48;
    localparam int LEVEL_W       = 19;
    localparam int SCALE_W       = 16;
    localparam int MASK_W        = 24;

    localparam int COEF_FRAC     = 14;
    localparam int LEVEL_SHIFT   = 2 * COEF_FRAC;
    localparam int PIX_FRAC      = COEF_FRAC + 8;
    localparam int HALF_SHIFT    = PIX_FRAC - 1;

    localparam int PROD_W        = COEF_W + COORD_W;
    localparam int T_W           = PROD_W + 1;
    localparam int HPROD_W       = COEF_W + T_W;
    localparam int H_W           = HPROD_W + 2;
    localparam int SC_W          = T_W + SCALE_W + 1;
    localparam int V_W           = SC_W + 1;
    localparam int P_W           = V_W - 1 - PIX_FRAC;

    localparam int QUEUE_DEPTH   = 2;
    localparam int Q_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);
    localparam logic [MASK_W-1:0]  MASK_RESET  = MASK_W'(24'h200200);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X        = 4'd0,
        REG_ROW_Y        = 4'd1,
        REG_ROW_Z        = 4'd2,
        REG_SLAB_NORMAL  = 4'd3,
        REG_TOP_LEVEL    = 4'd4,
        REG_BOTTOM_LEVEL = 4'd5,
        REG_PIXELS_PER_MM = 4'd6,
        REG_MASK_SIZE    = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] row_x;
        logic [CFG_DATA_W-1:0] row_y;
        logic [CFG_DATA_W-1:0] row_z;
        logic [NORMAL_W-1:0]   slab_normal;
        logic [LEVEL_W-1:0]    top_level;
        logic [LEVEL_W-1:0]    bottom_level;
        logic [SCALE_W-1:0]    pixels_per_mm;
        logic [MASK_W-1:0]     mask_size;
    } psp_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               frame_end;
        logic               measured;
    } psp_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } psp_q_status_t;

endpackage

`default_nettype wire

// File: design/psp_front.sv
// request intake stage: registers a point and marks zero-depth points
`default_nettype none

module psp_front import psp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [COORD_W-1:0] point_z,
    input  logic               frame_end,
    input  psp_q_status_t      q_status,
    output logic               busy,
    output logic               push,
    output psp_item_t          item
);

    logic      valid_reg;
    logic      valid_next;
    psp_item_t item_reg;
    logic      accept;

    assign push   = valid_reg && !q_status.full;
    assign busy   = valid_reg && q_status.full;
    assign accept = start && !busy;
    assign item   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // zero depth carries no measurement
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.x         <= point_x;
            item_reg.y         <= point_y;
            item_reg.z         <= point_z;
            item_reg.frame_end <= frame_end;
            item_reg.measured  <= (point_z != '0);
        end
    end

endmodule

`default_nettype wire

// File: design/psp_queue.sv
// short request queue between intake and datapath
`default_nettype none

module psp_queue import psp_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psp_item_t     push_item,
    input  logic          pop,
    output psp_item_t     head,
    output psp_q_status_t status
);

    psp_item_t          entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: design/psp_back.sv
// five-stage datapath: transform, slab test, projection and mask test
`default_nettype none

module psp_back import psp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  psp_item_t        in_item,
    input  psp_cfg_t         cfg,
    output logic             done,
    output logic             hit,
    output logic [PIX_W-1:0] pixel_col,
    output logic [PIX_W-1:0] pixel_row,
    output logic             frame_done
);

    localparam logic signed [V_W-1:0] ONE_PIX = V_W'(1) <<< PIX_FRAC;

    // configuration fields
    logic [CFG_DATA_W-1:0]      rows [3];
    logic signed [COEF_W-1:0]   coef [3][3];
    logic signed [COEF_W-1:0]   offs [3];
    logic signed [COEF_W-1:0]   nrm [3];
    logic signed [COORD_W-1:0]  coord [3];
    logic signed [SCALE_W:0]    scale_s;
    logic [DIM_W-1:0]           width;
    logic [DIM_W-1:0]           height;

    // pipeline registers
    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                       s1_meas_reg, s2_meas_reg, s3_meas_reg, s4_meas_reg;
    logic                       s1_fe_reg, s2_fe_reg, s3_fe_reg, s4_fe_reg;
    logic signed [PROD_W-1:0]   s1_prod_reg [3][3];
    logic signed [COEF_W-1:0]   s1_off_reg [3];
    logic signed [T_W-1:0]      s2_t_reg [3];
    logic signed [HPROD_W-1:0]  s3_hp_reg [3];
    logic signed [SC_W-1:0]     s3_sc_reg [2];
    logic signed [H_W-1:0]      s4_h_reg;
    logic signed [V_W-1:0]      s4_vc_reg;
    logic signed [V_W-1:0]      s4_vr_reg;
    logic                       done_reg;
    logic                       hit_reg;
    logic [PIX_W-1:0]           col_reg;
    logic [PIX_W-1:0]           row_reg;
    logic                       fd_reg;

    // last stage combinational
    logic signed [H_W-1:0]      top_q;
    logic signed [H_W-1:0]      bot_q;
    logic                       in_slab;
    logic                       col_ok;
    logic                       row_ok;
    logic                       hit_next;

    function automatic logic proj_ok(input logic signed [V_W-1:0] v,
                                     input logic [DIM_W-1:0] size);
        logic [P_W-1:0] p;
        p = v[V_W-2:PIX_FRAC];
        if (v < 0)
        begin
            // fraction in (-1, 0) truncates to pixel zero
            return (v > -ONE_PIX) && (size != '0);
        end
        return p < P_W'(size);
    endfunction

    function automatic logic [PIX_W-1:0] proj_pix(input logic signed [V_W-1:0] v);
        return (v < 0) ? '0 : v[PIX_FRAC+PIX_W-1:PIX_FRAC];
    endfunction

    assign rows[0] = cfg.row_x;
    assign rows[1] = cfg.row_y;
    assign rows[2] = cfg.row_z;
    assign coord[0] = $signed(in_item.x);
    assign coord[1] = $signed(in_item.y);
    assign coord[2] = $signed(in_item.z);
    assign nrm[0]  = $signed(cfg.slab_normal[3*COEF_W-1:2*COEF_W]);
    assign nrm[1]  = $signed(cfg.slab_normal[2*COEF_W-1:COEF_W]);
    assign nrm[2]  = $signed(cfg.slab_normal[COEF_W-1:0]);
    assign scale_s = $signed({1'b0, cfg.pixels_per_mm});
    assign width   = DIM_W'(cfg.mask_size >> MASK_DIM_BITS);
    assign height  = DIM_W'(cfg.mask_size);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                coef[r][c] = $signed(rows[r][CFG_DATA_W-1-c*COEF_W -: COEF_W]);
            end
            offs[r] = $signed(rows[r][COEF_W-1:0]);
        end
    end

    assign top_q    = H_W'($signed(cfg.top_level)) <<< LEVEL_SHIFT;
    assign bot_q    = H_W'($signed(cfg.bottom_level)) <<< LEVEL_SHIFT;
    assign in_slab  = (s4_h_reg <= top_q) && (s4_h_reg >= bot_q);
    assign col_ok   = proj_ok(s4_vc_reg, width);
    assign row_ok   = proj_ok(s4_vr_reg, height);
    assign hit_next = s4_meas_reg && in_slab && col_ok && row_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: nine coefficient products
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s1_prod_reg[r][c] <= PROD_W'(coef[r][c] * coord[c]);
            end
            s1_off_reg[r] <= offs[r];
        end
        s1_meas_reg <= in_item.measured;
        s1_fe_reg   <= in_item.frame_end;

        // stage 2: transformed coordinates in Q.14
        for (int r = 0; r < 3; r++)
        begin
            s2_t_reg[r] <= T_W'(s1_prod_reg[r][0]) + T_W'(s1_prod_reg[r][1])
                         + T_W'(s1_prod_reg[r][2]) + (T_W'(s1_off_reg[r]) <<< COEF_FRAC);
        end
        s2_meas_reg <= s1_meas_reg;
        s2_fe_reg   <= s1_fe_reg;

        // stage 3: height products and scaled coordinates
        for (int i = 0; i < 3; i++)
        begin
            s3_hp_reg[i] <= HPROD_W'(nrm[i]) * HPROD_W'(s2_t_reg[i]);
        end
        s3_sc_reg[0] <= SC_W'(s2_t_reg[0]) * SC_W'(scale_s);
        s3_sc_reg[1] <= SC_W'(s2_t_reg[1]) * SC_W'(scale_s);
        s3_meas_reg  <= s2_meas_reg;
        s3_fe_reg    <= s2_fe_reg;

        // stage 4: height sum and half-size centering
        s4_h_reg    <= H_W'(s3_hp_reg[0]) + H_W'(s3_hp_reg[1]) + H_W'(s3_hp_reg[2]);
        s4_vc_reg   <= V_W'(s3_sc_reg[0]) + (V_W'(width) <<< HALF_SHIFT);
        s4_vr_reg   <= V_W'(s3_sc_reg[1]) + (V_W'(height) <<< HALF_SHIFT);
        s4_meas_reg <= s3_meas_reg;
        s4_fe_reg   <= s3_fe_reg;

        // stage 5: slab and mask tests, result register
        hit_reg <= hit_next;
        col_reg <= hit_next ? proj_pix(s4_vc_reg) : '0;
        row_reg <= hit_next ? proj_pix(s4_vr_reg) : '0;
        fd_reg  <= s4_fe_reg;
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign pixel_col  = col_reg;
    assign pixel_row  = row_reg;
    assign frame_done = fd_reg;

endmodule

`default_nettype wire

// File: design/point_slab_pixel_projector.sv
// top level of the point slab pixel projector
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  request   | start / busy               | point_x, point_y, point_z, frame_end
//  result    | done (one-cycle strobe)    | hit, pixel_col, pixel_row, frame_done
//  config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// one request per clock; done rises once the accepted request has passed the
// intake register, queue slot, four multiply/add stages and result register
// the queue drains one request per cycle and the datapath never stalls, so
// busy only rises if the queue backs up; the receiver cannot stall results
// rst_n clears all valid bits and restores the register reset values;
// cfg_ready is always high and writes are expected only while idle
`default_nettype none
`include "point_slab_pixel_projector_defines.svh"

module point_slab_pixel_projector import psp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    point_x,
    input  logic [COORD_W-1:0]    point_y,
    input  logic [COORD_W-1:0]    point_z,
    input  logic                  frame_end,
    // result channel
    output logic                  done,
    output logic                  hit,
    output logic [PIX_W-1:0]      pixel_col,
    output logic [PIX_W-1:0]      pixel_row,
    output logic                  frame_done,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [CFG_DATA_W-1:0] row_x_reg;
    logic [CFG_DATA_W-1:0] row_y_reg;
    logic [CFG_DATA_W-1:0] row_z_reg;
    logic [NORMAL_W-1:0]   slab_normal_reg;
    logic [LEVEL_W-1:0]    top_level_reg;
    logic [LEVEL_W-1:0]    bottom_level_reg;
    logic [SCALE_W-1:0]    scale_reg;
    logic [MASK_W-1:0]     mask_size_reg;
    psp_cfg_t              cfg;
    logic                  cfg_write;

    // front to queue to back
    logic                  push;
    psp_item_t             front_item;
    psp_item_t             head_item;
    psp_q_status_t         q_status;
    logic                  pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg        <= '0;
            row_y_reg        <= '0;
            row_z_reg        <= '0;
            slab_normal_reg  <= '0;
            top_level_reg    <= '0;
            bottom_level_reg <= '0;
            scale_reg        <= SCALE_RESET;
            mask_size_reg    <= MASK_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_ROW_X:         row_x_reg        <= cfg_data;
                REG_ROW_Y:         row_y_reg        <= cfg_data;
                REG_ROW_Z:         row_z_reg        <= cfg_data;
                REG_SLAB_NORMAL:   slab_normal_reg  <= cfg_data[NORMAL_W-1:0];
                REG_TOP_LEVEL:     top_level_reg    <= cfg_data[LEVEL_W-1:0];
                REG_BOTTOM_LEVEL:  bottom_level_reg <= cfg_data[LEVEL_W-1:0];
                REG_PIXELS_PER_MM: scale_reg        <= cfg_data[SCALE_W-1:0];
                REG_MASK_SIZE:     mask_size_reg    <= cfg_data[MASK_W-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg.row_x         = row_x_reg;
    assign cfg.row_y         = row_y_reg;
    assign cfg.row_z         = row_z_reg;
    assign cfg.slab_normal   = slab_normal_reg;
    assign cfg.top_level     = top_level_reg;
    assign cfg.bottom_level  = bottom_level_reg;
    assign cfg.pixels_per_mm = scale_reg;
    assign cfg.mask_size     = mask_size_reg;

    // intake: registers the request and flags zero depth
    psp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .frame_end (frame_end),
        .q_status  (q_status),
        .busy      (busy),
        .push      (push),
        .item      (front_item)
    );

    // datapath pulls whenever the queue holds a request
    assign pop = !q_status.empty;

    psp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (head_item),
        .status    (q_status)
    );

    psp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pop),
        .in_item    (head_item),
        .cfg        (cfg),
        .done       (done),
        .hit        (hit),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .frame_done (frame_done)
    );

    // a miss always reports pixel zero
    `PSP_ASSERT_IMPLY(a_miss_zero_pixel, clk, rst_n, done && !hit, (pixel_col == '0) && (pixel_row == '0))

    // the datapath keeps pace, so the queue never backs up
    `PSP_ASSERT_IMPLY(a_never_busy, clk, rst_n, start, !busy)

    // fixed latency from acceptance to result strobe
    `PSP_ASSERT_DELAY(a_fixed_latency, clk, rst_n, start && !busy, 7, done)

endmodule

`default_nettype wire
